@@ design/iira_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iira_pkg
// Shared types and codes for the indexed insert/remove array.
// ----------------------------------------------------------------------------
package iira_pkg;

  localparam int unsigned CAPACITY_DEF = 64;
  localparam int unsigned FUNC_W       = 3;
  localparam int unsigned IDX_W        = 7;
  localparam int unsigned VAL_W        = 32;
  localparam int unsigned STAT_W       = 2;

  localparam logic [FUNC_W-1:0] FN_APPEND = 3'd0;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd1;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd2;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_WRITE  = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  // What every cell does with the broadcast command
  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_PUT,   // cell at pos takes the value
    ACT_INS,   // cell at pos takes the value, cells above take lower neighbor
    ACT_DEL,   // cells at pos and above take upper neighbor
    ACT_READ   // cell at pos drives its word onto the read row
  } iira_act_e;

  typedef struct packed {
    iira_act_e         act;
    logic [VAL_W-1:0]  value;
  } iira_ctrl_t;

endpackage

@@ design/iira_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iira_cell
// One storage slot of the array; shifts with its neighbors on insert/remove.
// ----------------------------------------------------------------------------
module iira_cell import iira_pkg::*; #(
  parameter int unsigned PW  = 7,
  parameter int unsigned POS = 0
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  iira_ctrl_t       ctrl_i,
  input  logic [PW-1:0]    pos_i,
  input  logic [VAL_W-1:0] lower_i,
  input  logic [VAL_W-1:0] upper_i,
  output logic [VAL_W-1:0] data_o,
  output logic [VAL_W-1:0] rd_o
);

  localparam logic [PW-1:0] MY_POS = PW'(POS);

  logic [VAL_W-1:0] data_q, data_d;
  logic [VAL_W-1:0] rd_q, rd_d;
  logic             hit, above;

  assign hit   = (pos_i == MY_POS);
  assign above = (MY_POS > pos_i);

  always_comb begin
    data_d = data_q;
    rd_d   = '0;
    case (ctrl_i.act)
      ACT_PUT: begin
        if (hit) data_d = ctrl_i.value;
      end
      ACT_INS: begin
        if (hit) data_d = ctrl_i.value;
        else if (above) data_d = lower_i;
      end
      ACT_DEL: begin
        if (hit || above) data_d = upper_i;
      end
      ACT_READ: begin
        if (hit) rd_d = data_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
      rd_q   <= rd_d;
    end
  end

  assign data_o = data_q;
  assign rd_o   = rd_q;

endmodule

@@ design/indexed_insert_remove_array.sv @@
`timescale 1ns / 1ps
// An accepted beat sets the pending flag and loads the addressed cell's read
// register; the pending beat then gathers the read word from the row of cells
// into the output register. No new beat is accepted while one is pending.
// Insert and remove shift the cells at and above the index in the accept cycle.
// Reset clears the element count and the handshake state; cell contents stay
// undefined until written. No clearing pass.
// ----------------------------------------------------------------------------
// indexed_insert_remove_array
// Ordered array of signed words held in a row of shifting cells.
// ----------------------------------------------------------------------------
module indexed_insert_remove_array import iira_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic [IDX_W-1:0]         index_i,
  input  logic signed [VAL_W-1:0]  value_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [VAL_W-1:0]  read_value_o,
  output logic [IDX_W-1:0]         element_count_o,
  output logic                     is_empty_o,
  output logic [STAT_W-1:0]        status_o
);

  localparam int unsigned CW   = $clog2(CAPACITY + 1);
  localparam int unsigned PW   = (CW > IDX_W) ? CW : IDX_W;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);

  logic              in_fire;
  logic              pend_q;
  logic              out_valid_q;
  logic [CW-1:0]     count_q, count_d;
  logic [STAT_W-1:0] stat_q, stat_d;
  logic [PW-1:0]     cnt_ext, idx_ext, pos;
  logic              full;
  iira_ctrl_t        ctrl;

  logic [VAL_W-1:0]  cell_data [CAPACITY];
  logic [VAL_W-1:0]  cell_rd   [CAPACITY];
  logic [VAL_W-1:0]  rd_or;

  assign in_ready_o = !pend_q && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;

  assign cnt_ext = PW'(count_q);
  assign idx_ext = PW'(index_i);
  assign full    = (cnt_ext >= CAP_P);

  // Decode the beat into a broadcast cell command and the new count
  always_comb begin
    ctrl.act   = ACT_NONE;
    ctrl.value = value_i;
    pos        = idx_ext;
    count_d    = count_q;
    stat_d     = ST_OK;
    case (func_i)
      FN_APPEND: begin
        if (full) begin
          stat_d = ST_FULL;
        end else begin
          ctrl.act = ACT_PUT;
          pos      = cnt_ext;
          count_d  = CW'(count_q + 1'b1);
        end
      end
      FN_INSERT: begin
        if (idx_ext > cnt_ext) begin
          stat_d = ST_RANGE;
        end else if (full) begin
          stat_d = ST_FULL;
        end else begin
          ctrl.act = ACT_INS;
          count_d  = CW'(count_q + 1'b1);
        end
      end
      FN_REMOVE: begin
        if (count_q == '0) begin
          stat_d = ST_EMPTY;
        end else if (idx_ext >= cnt_ext) begin
          stat_d = ST_RANGE;
        end else begin
          ctrl.act = ACT_DEL;
          count_d  = CW'(count_q - 1'b1);
        end
      end
      FN_READ: begin
        if (idx_ext >= cnt_ext) stat_d = ST_RANGE;
        else ctrl.act = ACT_READ;
      end
      FN_WRITE: begin
        if (idx_ext >= cnt_ext) stat_d = ST_RANGE;
        else ctrl.act = ACT_PUT;
      end
      FN_CLEAR: begin
        count_d = '0;
      end
      default: ;
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [VAL_W-1:0] lower, upper;
    if (g == 0) begin : g_bot
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_top
      assign upper = cell_data[g];
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end
    iira_cell #(.PW(PW), .POS(g)) u_cell (
      .clk_i   (clk_i),
      .en_i    (in_fire),
      .ctrl_i  (ctrl),
      .pos_i   (pos),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[g]),
      .rd_o    (cell_rd[g])
    );
  end

  // Only the addressed cell drives a nonzero word on a read
  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) rd_or = rd_or | cell_rd[i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= '0;
    end else begin
      if (in_fire) begin
        pend_q  <= 1'b1;
        count_q <= count_d;
      end else if (pend_q) begin
        pend_q <= 1'b0;
      end
      if (pend_q) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) stat_q <= stat_d;
    if (pend_q) begin
      read_value_o    <= rd_or;
      element_count_o <= cnt_ext[IDX_W-1:0];
      is_empty_o      <= (count_q == '0);
      status_o        <= stat_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ design/iira_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iira_check
// Port-level checks for the indexed insert/remove array.
// ----------------------------------------------------------------------------
module iira_check import iira_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_ready_o,
  input logic [FUNC_W-1:0]        func_i,
  input logic [IDX_W-1:0]         index_i,
  input logic signed [VAL_W-1:0]  value_i,
  input logic                     out_valid_o,
  input logic                     out_ready_i,
  input logic signed [VAL_W-1:0]  read_value_o,
  input logic [IDX_W-1:0]         element_count_o,
  input logic                     is_empty_o,
  input logic [STAT_W-1:0]        status_o
);

  // A held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(read_value_o)
      && $stable(status_o) && $stable(element_count_o))
    else $error("result beat changed while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (element_count_o == '0)))
    else $error("empty flag disagrees with count");

  a_rd_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (read_value_o != '0) |-> (status_o == ST_OK))
    else $error("nonzero read word on a rejected beat");

  a_empty_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> is_empty_o)
    else $error("remove-on-empty reported with elements present");

endmodule

bind indexed_insert_remove_array iira_check u_iira_check (.*);
